/* src/shc_pkg.sv */
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types, codes and helpers for the stepper axis homing controller.
// ----------------------------------------------------------------------------
package shc_pkg;

    // Width of the internal step position counter
    localparam int POS_BITS   = 32;
    // Output position width and the widths used to extend/compare
    localparam int POS_OUT_W  = 32;
    localparam int POS_EXT_W  = (POS_BITS > POS_OUT_W) ? POS_BITS : POS_OUT_W;
    localparam int TARGET_W   = 31;
    localparam int CMP_W      = (POS_BITS > TARGET_W) ? POS_BITS : TARGET_W;
    localparam int DB_W       = 16;

    // Debounce window after reset, in millisecond ticks
    localparam logic [DB_W-1:0] DEBOUNCE_RESET = 16'd25;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOMING = 2'd1,
        MODE_MOVING = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_STEP    = 3'd0,
        KIND_CMD     = 3'd1,
        KIND_TOP     = 3'd2,
        KIND_BOTTOM  = 3'd3,
        KIND_MS_TICK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CMD_STOP     = 3'd0,
        CMD_RUN      = 3'd1,
        CMD_HOME     = 3'd2,
        CMD_MOVE     = 3'd3,
        CMD_SET_UP   = 3'd4,
        CMD_SET_DOWN = 3'd5,
        CMD_REPORT   = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        ST_NONE         = 4'd0,
        ST_BLOCKED_UP   = 4'd1,
        ST_BLOCKED_DOWN = 4'd2,
        ST_ALREADY_UP   = 4'd3,
        ST_ALREADY_DOWN = 4'd4,
        ST_DIR_CHANGED  = 4'd5,
        ST_HOMING       = 4'd6,
        ST_ZEROED       = 4'd7,
        ST_REPORT       = 4'd8
    } status_t;

    // One event item as held in the input register
    typedef struct packed {
        logic [2:0]          kind;
        logic [2:0]          command_code;
        logic [TARGET_W-1:0] move_count;
    } shc_item_t;

    // One result item as held in the result register
    typedef struct packed {
        logic                 step_pulse;
        logic                 dir_up;
        logic                 motor_enable;
        logic [1:0]           mode;
        logic [POS_OUT_W-1:0] position;
        logic                 top_pressed;
        logic                 bottom_pressed;
        logic [3:0]           status;
    } shc_result_t;

    // Sign-extend or cut the internal position to the output width
    function automatic logic [POS_OUT_W-1:0] pos_out(input logic [POS_BITS-1:0] p);
        logic [POS_EXT_W-1:0] ext;
        ext = POS_EXT_W'($signed(p));
        return ext[POS_OUT_W-1:0];
    endfunction

endpackage

/* src/shc_ifs.sv */
// ----------------------------------------------------------------------------
// shc interfaces
// Valid/ready channels for events, results and the debounce config write.
// ----------------------------------------------------------------------------
interface shc_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  command_code;
    logic [30:0] move_count;

    modport source (output valid, kind, command_code, move_count, input ready);
    modport sink   (input valid, kind, command_code, move_count, output ready);
endinterface

interface shc_rsp_if;
    logic        valid;
    logic        ready;
    logic        step_pulse;
    logic        dir_up;
    logic        motor_enable;
    logic [1:0]  mode;
    logic signed [31:0] position;
    logic        top_pressed;
    logic        bottom_pressed;
    logic [3:0]  status;

    modport source (output valid, step_pulse, dir_up, motor_enable, mode, position,
                    top_pressed, bottom_pressed, status, input ready);
    modport sink   (input valid, step_pulse, dir_up, motor_enable, mode, position,
                    top_pressed, bottom_pressed, status, output ready);
endinterface

interface shc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/shc_in_stage.sv */
// ----------------------------------------------------------------------------
// shc_in_stage
// Input register: holds one event until the core consumes it.
// ----------------------------------------------------------------------------
module shc_in_stage
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    shc_evt_if.sink     evt,
    input  logic        take,
    output logic        item_valid,
    output shc_item_t   item
);

    logic      valid_reg;
    logic      valid_next;
    shc_item_t item_reg;
    logic      evt_fire;

    // Ready whenever the slot is empty or drains this cycle
    assign evt.ready = !valid_reg || take;
    assign evt_fire  = evt.valid && evt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (evt_fire)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            item_reg.kind         <= evt.kind;
            item_reg.command_code <= evt.command_code;
            item_reg.move_count   <= evt.move_count;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/shc_core.sv */
// ----------------------------------------------------------------------------
// shc_core
// Axis state and the single-pass event update: mode, direction, position,
// counted move, endstop flags and debounce window.
// ----------------------------------------------------------------------------
module shc_core
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    shc_cfg_if.sink     cfg,
    input  logic        fire,
    input  shc_item_t   item,
    output shc_result_t res_next
);

    // State
    mode_t                mode_reg, mode_next;
    logic                 dir_reg, dir_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [POS_BITS-1:0]  origin_reg, origin_next;
    logic [TARGET_W-1:0]  target_reg, target_next;
    logic                 counted_reg, counted_next;
    logic                 top_reg, top_next;
    logic                 bottom_reg, bottom_next;
    logic [DB_W-1:0]      db_count_reg, db_count_next;
    logic [DB_W-1:0]      db_ticks_reg;

    // Step helpers
    logic [POS_BITS-1:0]  pos_up;
    logic [POS_BITS-1:0]  pos_down;
    logic [POS_BITS-1:0]  pos_moved;
    logic [POS_BITS-1:0]  travel;
    logic [POS_BITS-1:0]  travel_abs;
    logic                 target_reached;
    logic                 window_open;
    logic                 blk_up;
    logic                 blk_down;
    logic                 pulse;
    status_t              status;
    kind_t                kind;
    cmd_t                 cmd;

    assign kind = kind_t'(item.kind);
    assign cmd  = cmd_t'(item.command_code);

    // Config write port never stalls
    assign cfg.ready = 1'b1;

    // Up steps count down, down steps count up
    assign pos_up    = pos_reg - POS_BITS'(1);
    assign pos_down  = pos_reg + POS_BITS'(1);
    assign pos_moved = dir_reg ? pos_up : pos_down;

    // Distance from move origin after a moving step
    assign travel         = pos_moved - origin_reg;
    assign travel_abs     = travel[POS_BITS-1] ? (POS_BITS'(0) - travel) : travel;
    assign target_reached = CMP_W'(travel_abs) >= CMP_W'(target_reg);

    assign window_open = db_count_reg >= db_ticks_reg;
    assign blk_up      = top_reg && dir_reg;
    assign blk_down    = bottom_reg && !dir_reg;

    // Next state and result
    always_comb
    begin
        mode_next     = mode_reg;
        dir_next      = dir_reg;
        pos_next      = pos_reg;
        origin_next   = origin_reg;
        target_next   = target_reg;
        counted_next  = counted_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        db_count_next = db_count_reg;
        pulse         = 1'b0;
        status        = ST_NONE;

        case (kind)
            KIND_STEP:
            begin
                if (mode_reg == MODE_HOMING)
                begin
                    if (top_reg)
                    begin
                        pos_next  = '0;
                        mode_next = MODE_IDLE;
                        status    = ST_ZEROED;
                    end
                    else
                    begin
                        // homing always drives up
                        dir_next = 1'b1;
                        pos_next = pos_up;
                        pulse    = 1'b1;
                    end
                end
                else if (mode_reg == MODE_MOVING)
                begin
                    pos_next = pos_moved;
                    pulse    = 1'b1;
                    if (counted_reg && target_reached)
                    begin
                        counted_next = 1'b0;
                        mode_next    = MODE_IDLE;
                    end
                end
            end

            KIND_CMD:
            begin
                unique case (cmd)
                    CMD_STOP:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    CMD_RUN, CMD_MOVE:
                    begin
                        if (cmd == CMD_MOVE)
                        begin
                            target_next = item.move_count;
                        end
                        if (blk_up)
                        begin
                            status = ST_BLOCKED_UP;
                        end
                        else if (blk_down)
                        begin
                            status = ST_BLOCKED_DOWN;
                        end
                        else
                        begin
                            mode_next = MODE_MOVING;
                            if (cmd == CMD_MOVE)
                            begin
                                origin_next  = pos_reg;
                                counted_next = 1'b1;
                            end
                            else
                            begin
                                counted_next = 1'b0;
                            end
                        end
                    end
                    CMD_HOME:
                    begin
                        mode_next = MODE_HOMING;
                        status    = ST_HOMING;
                    end
                    CMD_SET_UP:
                    begin
                        dir_next = 1'b1;
                        status   = dir_reg ? ST_ALREADY_UP : ST_DIR_CHANGED;
                    end
                    CMD_SET_DOWN:
                    begin
                        dir_next = 1'b0;
                        status   = dir_reg ? ST_DIR_CHANGED : ST_ALREADY_DOWN;
                    end
                    CMD_REPORT:
                    begin
                        status = ST_REPORT;
                    end
                    default:
                    begin
                        status = ST_NONE;
                    end
                endcase
            end

            KIND_TOP:
            begin
                if (window_open)
                begin
                    db_count_next = '0;
                    if (dir_reg)
                    begin
                        mode_next = MODE_IDLE;
                        pos_next  = '0;
                        top_next  = 1'b1;
                        status    = ST_ZEROED;
                    end
                    else
                    begin
                        top_next = 1'b0;
                    end
                end
            end

            KIND_BOTTOM:
            begin
                if (window_open)
                begin
                    db_count_next = '0;
                    if (!dir_reg)
                    begin
                        mode_next   = MODE_IDLE;
                        bottom_next = 1'b1;
                    end
                    else
                    begin
                        bottom_next = 1'b0;
                    end
                end
            end

            KIND_MS_TICK:
            begin
                if (!window_open)
                begin
                    db_count_next = db_count_reg + DB_W'(1);
                end
            end

            default:
            begin
                status = ST_NONE;
            end
        endcase
    end

    // Result as seen after this event
    always_comb
    begin
        res_next.step_pulse     = pulse;
        res_next.dir_up         = dir_next;
        res_next.motor_enable   = (mode_next != MODE_IDLE) || pulse;
        res_next.mode           = mode_next;
        res_next.position       = pos_out(pos_next);
        res_next.top_pressed    = top_next;
        res_next.bottom_pressed = bottom_next;
        res_next.status         = status;
    end

    // State registers advance once per consumed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            dir_reg      <= 1'b1;
            pos_reg      <= '0;
            origin_reg   <= '0;
            target_reg   <= '0;
            counted_reg  <= 1'b0;
            top_reg      <= 1'b0;
            bottom_reg   <= 1'b0;
            db_count_reg <= DEBOUNCE_RESET;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            dir_reg      <= dir_next;
            pos_reg      <= pos_next;
            origin_reg   <= origin_next;
            target_reg   <= target_next;
            counted_reg  <= counted_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
            db_count_reg <= db_count_next;
        end
    end

    // Debounce window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_ticks_reg <= DEBOUNCE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            db_ticks_reg <= cfg.data;
        end
    end

`ifndef ASSERT_OFF
    // State only moves when an event is consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg) && $stable(mode_reg) && $stable(dir_reg))
        else $error("shc_core: state changed without an event");

    // Accepted top edge while heading up zeroes position and idles the axis
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind == KIND_TOP) && window_open && dir_reg
        |=> (pos_reg == '0) && (mode_reg == MODE_IDLE) && top_reg)
        else $error("shc_core: top endstop did not zero the axis");

    // Homing step with top pressed never issues a pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind == KIND_STEP) && (mode_reg == MODE_HOMING) && top_reg
        |-> !res_next.step_pulse && (res_next.status == ST_ZEROED))
        else $error("shc_core: pulse issued while homed");

    // Idle axis never steps
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (mode_reg == MODE_IDLE) |=> $stable(pos_reg) || (pos_reg == '0))
        else $error("shc_core: position moved while idle");
`endif

endmodule

/* src/shc_out_stage.sv */
// ----------------------------------------------------------------------------
// shc_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module shc_out_stage
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  shc_result_t res_next,
    output logic        space,
    shc_rsp_if.source   rsp
);

    logic        valid_reg;
    logic        valid_next;
    shc_result_t res_reg;

    // Free when empty or emptied this cycle
    assign space = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.step_pulse     = res_reg.step_pulse;
    assign rsp.dir_up         = res_reg.dir_up;
    assign rsp.motor_enable   = res_reg.motor_enable;
    assign rsp.mode           = res_reg.mode;
    assign rsp.position       = $signed(res_reg.position);
    assign rsp.top_pressed    = res_reg.top_pressed;
    assign rsp.bottom_pressed = res_reg.bottom_pressed;
    assign rsp.status         = res_reg.status;

endmodule

/* src/stepper_axis_homing_controller_top.sv */
// ----------------------------------------------------------------------------
// stepper_axis_homing_controller_top
// One stepper axis with endstop homing, counted moves and debounced endstops.
//
//   channel | dir  | transfer carries
//   --------+------+-----------------------------------------------------
//   evt     | sink | kind, command_code, move_count
//   rsp     | src  | step_pulse, dir_up, motor_enable, mode, position,
//           |      | top_pressed, bottom_pressed, status
//   cfg     | sink | data = debounce_ticks
//
// One event per cycle sustained while rsp takes results; each event yields
// one result, through the input register, then the result register.
// The core updates all axis state in the same cycle the event leaves the
// input register, so the next event always sees the updated state.
// Reset: axis idle, direction up, position 0, debounce window expired (25).
// evt.ready drops only when both registers are full and rsp is stalled.
// cfg is always ready.
// ----------------------------------------------------------------------------
module stepper_axis_homing_controller_top
    import shc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    shc_evt_if.sink   evt,
    shc_rsp_if.source rsp,
    shc_cfg_if.sink   cfg
);

    logic        item_valid;
    shc_item_t   item;
    logic        space;
    logic        fire;
    shc_result_t res_next;

    // Event is consumed when the result register has room
    assign fire = item_valid && space;

    shc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .take       (space),
        .item_valid (item_valid),
        .item       (item)
    );

    shc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .fire     (fire),
        .item     (item),
        .res_next (res_next)
    );

    shc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res_next (res_next),
        .space    (space),
        .rsp      (rsp)
    );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper axis homing controller. An in-bench
// copy of the axis state (mode, direction, position, counted move, endstop
// flags, debounce window) predicts the response to every accepted event.
// Each response transfer is compared field by field with the oldest
// prediction. Directed sequences come first: all commands, blocked starts,
// homing, endstop edges and the debounce window. Then random events run
// under several debounce settings, with random gaps on both channels and one
// long response stall.
// ----------------------------------------------------------------------------
module tb_top
    import shc_pkg::*;
();

    localparam int CLK_PERIOD      = 20;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 300;

    // Event codes outside the defined set
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [2:0] CMD_SPARE        = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    shc_evt_if evt ();
    shc_rsp_if rsp ();
    shc_cfg_if cfg ();

    stepper_axis_homing_controller_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicted axis state
    mode_t       ax_mode;
    logic        ax_dir;
    logic [31:0] ax_pos;
    logic [31:0] ax_origin;
    logic [30:0] ax_target;
    logic        ax_counted;
    logic        ax_top;
    logic        ax_bottom;
    logic [15:0] ax_db_count;
    logic [15:0] ax_db_ticks;

    shc_result_t pending_axis_states[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // Idle controls shared by the driver, the response sink and the tests
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_left    = 0;
    int stall_left   = 0;

    // ------------------------------------------------------------------------
    // Axis predictor
    // ------------------------------------------------------------------------
    task automatic reset_axis_model();
        ax_mode     = MODE_IDLE;
        ax_dir      = 1'b1;
        ax_pos      = '0;
        ax_origin   = '0;
        ax_target   = '0;
        ax_counted  = 1'b0;
        ax_top      = 1'b0;
        ax_bottom   = 1'b0;
        ax_db_ticks = DEBOUNCE_RESET;
        ax_db_count = DEBOUNCE_RESET;
    endtask

    // Run or move toward a pressed endstop is refused
    function automatic status_t start_refusal();
        if (ax_top && ax_dir)
            return ST_BLOCKED_UP;
        if (ax_bottom && !ax_dir)
            return ST_BLOCKED_DOWN;
        return ST_NONE;
    endfunction

    task automatic predict_axis_event(input logic [2:0] k, input logic [2:0] c,
                                      input logic [30:0] n, output shc_result_t r);
        logic        pulse;
        status_t     st;
        logic [31:0] travel;
        pulse = 1'b0;
        st    = ST_NONE;
        case (k)
            KIND_STEP:
            begin
                if (ax_mode == MODE_HOMING)
                begin
                    if (ax_top)
                    begin
                        ax_pos  = '0;
                        ax_mode = MODE_IDLE;
                        st      = ST_ZEROED;
                    end
                    else
                    begin
                        ax_dir = 1'b1;
                        ax_pos = ax_pos - 1;
                        pulse  = 1'b1;
                    end
                end
                else if (ax_mode == MODE_MOVING)
                begin
                    ax_pos = ax_dir ? ax_pos - 1 : ax_pos + 1;
                    pulse  = 1'b1;
                    // counted move ends once the travelled magnitude reaches the target
                    if (ax_counted)
                    begin
                        travel = ax_pos - ax_origin;
                        if (travel[31])
                            travel = -travel;
                        if (travel >= {1'b0, ax_target})
                        begin
                            ax_counted = 1'b0;
                            ax_mode    = MODE_IDLE;
                        end
                    end
                end
            end
            KIND_CMD:
            begin
                case (c)
                    CMD_STOP:
                        ax_mode = MODE_IDLE;
                    CMD_RUN:
                    begin
                        st = start_refusal();
                        if (st == ST_NONE)
                        begin
                            ax_counted = 1'b0;
                            ax_mode    = MODE_MOVING;
                        end
                    end
                    CMD_HOME:
                    begin
                        st      = ST_HOMING;
                        ax_mode = MODE_HOMING;
                    end
                    CMD_MOVE:
                    begin
                        // target is loaded even when the move is refused
                        ax_target = n;
                        st        = start_refusal();
                        if (st == ST_NONE)
                        begin
                            ax_origin  = ax_pos;
                            ax_counted = 1'b1;
                            ax_mode    = MODE_MOVING;
                        end
                    end
                    CMD_SET_UP:
                    begin
                        st     = ax_dir ? ST_ALREADY_UP : ST_DIR_CHANGED;
                        ax_dir = 1'b1;
                    end
                    CMD_SET_DOWN:
                    begin
                        st     = ax_dir ? ST_DIR_CHANGED : ST_ALREADY_DOWN;
                        ax_dir = 1'b0;
                    end
                    CMD_REPORT:
                        st = ST_REPORT;
                    default:
                        ;
                endcase
            end
            KIND_TOP, KIND_BOTTOM:
            begin
                // edges inside the debounce window are dropped
                if (ax_db_count >= ax_db_ticks)
                begin
                    if (k == KIND_TOP)
                    begin
                        if (ax_dir)
                        begin
                            ax_mode = MODE_IDLE;
                            ax_pos  = '0;
                            ax_top  = 1'b1;
                            st      = ST_ZEROED;
                        end
                        else
                            ax_top = 1'b0;
                    end
                    else
                    begin
                        if (!ax_dir)
                        begin
                            ax_mode   = MODE_IDLE;
                            ax_bottom = 1'b1;
                        end
                        else
                            ax_bottom = 1'b0;
                    end
                    ax_db_count = '0;
                end
            end
            KIND_MS_TICK:
            begin
                if (ax_db_count < ax_db_ticks)
                    ax_db_count = ax_db_count + 16'd1;
            end
            default:
                ;
        endcase
        r.step_pulse     = pulse;
        r.dir_up         = ax_dir;
        r.motor_enable   = (ax_mode != MODE_IDLE) || pulse;
        r.mode           = ax_mode;
        r.position       = ax_pos;
        r.top_pressed    = ax_top;
        r.bottom_pressed = ax_bottom;
        r.status         = st;
    endtask

    // ------------------------------------------------------------------------
    // Gap lengths: mostly short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Event driver
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [2:0] k, input logic [2:0] c,
                              input logic [30:0] n);
        shc_result_t predicted;
        int          gap;
        gap = (src_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            evt.valid = 1'b0;
        end
        @(negedge clk);
        evt.valid        = 1'b1;
        evt.kind         = k;
        evt.command_code = c;
        evt.move_count   = n;
        do
            @(posedge clk);
        while (!evt.ready);
        predict_axis_event(k, c, n, predicted);
        pending_axis_states.push_back(predicted);
    endtask

    task automatic send_cmd(input logic [2:0] c, input logic [30:0] n);
        send_event(KIND_CMD, c, n);
    endtask

    // Non-command events carry junk in the unused fields
    task automatic send_kind(input logic [2:0] k);
        send_event(k, 3'($urandom), 31'($urandom));
    endtask

    // Drop valid and wait until every response has come back
    task automatic wait_drained();
        @(negedge clk);
        evt.valid = 1'b0;
        while (pending_axis_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] ticks);
        wait_drained();
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.data  = ticks;
        do
            @(posedge clk);
        while (!cfg.ready);
        ax_db_ticks = ticks;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response sink: ready pattern
    // ------------------------------------------------------------------------
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready = 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    initial
    begin
        shc_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (pending_axis_states.size() == 0)
                begin
                    $error("response transfer with no event outstanding");
                    mismatch_count++;
                end
                else
                begin
                    exp_r = pending_axis_states.pop_front();
                    check_field("step_pulse", 32'(exp_r.step_pulse),
                                32'(rsp.step_pulse));
                    check_field("dir_up", 32'(exp_r.dir_up), 32'(rsp.dir_up));
                    check_field("motor_enable", 32'(exp_r.motor_enable),
                                32'(rsp.motor_enable));
                    check_field("mode", 32'(exp_r.mode), 32'(rsp.mode));
                    check_field("position", exp_r.position, rsp.position);
                    check_field("top_pressed", 32'(exp_r.top_pressed),
                                32'(rsp.top_pressed));
                    check_field("bottom_pressed", 32'(exp_r.bottom_pressed),
                                32'(rsp.bottom_pressed));
                    check_field("status", 32'(exp_r.status), 32'(rsp.status));
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every command, spare codes, moves, homing and the first top edge
    task automatic test_commands();
        send_cmd(CMD_REPORT, '0);
        send_kind(KIND_SPARE_FIRST);
        send_kind(3'(KIND_SPARE_FIRST + 1));
        send_kind(KIND_SPARE_LAST);
        send_cmd(CMD_SPARE, '1);
        send_kind(KIND_STEP);
        send_cmd(CMD_SET_UP, '0);
        send_cmd(CMD_SET_DOWN, '0);
        send_cmd(CMD_SET_DOWN, '0);
        send_cmd(CMD_RUN, '0);
        send_kind(KIND_STEP);
        send_kind(KIND_STEP);
        send_cmd(CMD_STOP, '0);
        // a zero-step move still takes one step
        send_cmd(CMD_MOVE, '0);
        send_kind(KIND_STEP);
        send_cmd(CMD_SET_UP, '0);
        send_cmd(CMD_MOVE, 31'd3);
        repeat (4) send_kind(KIND_STEP);
        send_cmd(CMD_HOME, '0);
        send_kind(KIND_STEP);
        // top edge with the window expired from reset zeroes the axis
        send_kind(KIND_TOP);
        send_cmd(CMD_RUN, '0);
        send_cmd(CMD_MOVE, '1);
        send_cmd(CMD_HOME, '0);
        send_kind(KIND_STEP);
    endtask

    // Debounce window, endstop release and blocked-down starts
    task automatic test_endstops();
        write_debounce(16'd2);
        send_kind(KIND_TOP);
        send_kind(KIND_MS_TICK);
        send_kind(KIND_MS_TICK);
        send_cmd(CMD_SET_DOWN, '0);
        send_kind(KIND_TOP);
        send_cmd(CMD_RUN, '0);
        send_kind(KIND_STEP);
        send_kind(KIND_BOTTOM);
        repeat (3) send_kind(KIND_MS_TICK);
        send_kind(KIND_BOTTOM);
        send_cmd(CMD_RUN, '0);
        send_cmd(CMD_MOVE, 31'd5);
        send_cmd(CMD_SET_UP, '0);
        send_kind(KIND_MS_TICK);
        send_kind(KIND_MS_TICK);
        send_kind(KIND_BOTTOM);
        send_cmd(CMD_RUN, '0);
        send_kind(KIND_STEP);
        send_cmd(CMD_STOP, '0);
    endtask

    // One random event, weighted toward stepping and motion commands
    task automatic send_random_event();
        logic [2:0]  k;
        logic [2:0]  c;
        logic [30:0] n;
        int          r;
        r = $urandom_range(0, 99);
        c = 3'($urandom);
        n = 31'($urandom);
        if (r < 40)
            k = KIND_STEP;
        else if (r < 65)
            k = KIND_CMD;
        else if (r < 73)
            k = KIND_TOP;
        else if (r < 81)
            k = KIND_BOTTOM;
        else if (r < 96)
            k = KIND_MS_TICK;
        else
            k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        if (k == KIND_CMD)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                c = CMD_STOP;
            else if (r < 28)
                c = CMD_RUN;
            else if (r < 40)
                c = CMD_HOME;
            else if (r < 65)
                c = CMD_MOVE;
            else if (r < 77)
                c = CMD_SET_UP;
            else if (r < 89)
                c = CMD_SET_DOWN;
            else if (r < 97)
                c = CMD_REPORT;
            else
                c = CMD_SPARE;
            // mostly short moves so counted moves finish
            if (c == CMD_MOVE && $urandom_range(0, 99) < 85)
                n = 31'($urandom_range(0, 15));
        end
        send_event(k, c, n);
    endtask

    // Response side held off while events keep coming
    task automatic test_backpressure();
        wait_drained();
        src_idle_on = 1'b0;
        @(negedge clk);
        hold_left = LONG_HOLD;
        repeat (40) send_random_event();
        src_idle_on = 1'b1;
    endtask

    // Random events under a range of debounce windows
    task automatic test_random_phases();
        logic [15:0] windows[6];
        windows[0] = 16'd0;
        windows[1] = 16'd1;
        windows[2] = 16'd3;
        windows[3] = 16'hFFFF;
        windows[4] = 16'($urandom_range(4, 40));
        windows[5] = DEBOUNCE_RESET;
        foreach (windows[i])
        begin
            write_debounce(windows[i]);
            for (int j = 0; j < ITEMS_PER_PHASE; j++)
            begin
                // reshuffle idling every so often, including quiet stretches
                if (j % 64 == 0)
                begin
                    src_idle_on  = ($urandom_range(0, 9) < 7);
                    sink_idle_on = ($urandom_range(0, 9) < 7);
                end
                send_random_event();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        evt.valid        = 1'b0;
        evt.kind         = '0;
        evt.command_code = '0;
        evt.move_count   = '0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        reset_axis_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_endstops();
        test_backpressure();
        test_random_phases();

        wait_drained();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
